// ===== rtl/ll1p_pkg.sv =====
// Package for the LL(1) predictive parser: request and result structs,
// opcode, status and register index codes, sequencer states and default sizes.
// No dependencies.
`default_nettype none

package ll1p_pkg;

    localparam int NUM_NONTERMINALS_DEF = 16;
    localparam int NUM_TERMINALS_DEF    = 16;
    localparam int NUM_RULES_DEF        = 64;
    localparam int MAX_RULE_LENGTH_DEF  = 8;
    localparam int STACK_DEPTH_DEF      = 64;

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_TOKEN  = 3'd1;
    localparam logic [2:0] OP_TABLE  = 3'd2;
    localparam logic [2:0] OP_SYMBOL = 3'd3;
    localparam logic [2:0] OP_LENGTH = 3'd4;

    localparam logic [2:0] ST_WRITTEN  = 3'd0;
    localparam logic [2:0] ST_STARTED  = 3'd1;
    localparam logic [2:0] ST_MATCHED  = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_FAULT    = 3'd5;
    localparam logic [2:0] ST_IDLE     = 3'd6;

    localparam logic [1:0] REG_START_VARIABLE = 2'd0;
    localparam logic [1:0] REG_END_MARKER     = 2'd1;
    localparam logic [1:0] REG_EXP_LIMIT      = 2'd2;

    localparam logic [3:0] START_VARIABLE_RST = 4'd0;
    localparam logic [3:0] END_MARKER_RST     = 4'd15;
    localparam logic [7:0] EXP_LIMIT_RST      = 8'd64;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] nonterminal;
        logic [3:0] terminal;
        logic [5:0] rule_number;
        logic       entry_valid;
        logic [2:0] position_in_rule;
        logic [4:0] symbol_code;
        logic [3:0] rule_length;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] token_position;
        logic [7:0]  expansions_done;
        logic [6:0]  stack_level;
    } rsp_t;

    typedef struct packed {
        logic [3:0] start_variable;
        logic [3:0] end_marker_terminal;
        logic [7:0] expansion_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START1,
        S_TOP,
        S_CHK,
        S_ENT,
        S_LEN,
        S_PRD,
        S_PWR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/ll1p_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ll1p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ll1p_core.sv =====
// Parser core: sequencer, parse registers, prediction table, rule storage and
// symbol stack. Depends on ll1p_pkg and ll1p_ram.
`default_nettype none

module ll1p_core #(
    parameter int NUM_NONTERMINALS = ll1p_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_TERMINALS    = ll1p_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_RULES        = ll1p_pkg::NUM_RULES_DEF,
    parameter int MAX_RULE_LENGTH  = ll1p_pkg::MAX_RULE_LENGTH_DEF,
    parameter int STACK_DEPTH      = ll1p_pkg::STACK_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire ll1p_pkg::req_t   req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output ll1p_pkg::rsp_t        rsp,
    input  wire ll1p_pkg::cfg_t   cfg
);

    import ll1p_pkg::*;

    localparam int TAB_DEPTH = NUM_NONTERMINALS * NUM_TERMINALS;
    localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int SYM_DEPTH = NUM_RULES * MAX_RULE_LENGTH;
    localparam int SYM_AW    = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
    localparam int LEN_AW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int LEN_W     = $clog2(MAX_RULE_LENGTH + 1);
    localparam int STK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W      = $clog2(STACK_DEPTH + 1);

    state_t state_reg, state_next;

    logic [TAB_AW-1:0] clr_reg, clr_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [15:0]       count_reg, count_next;
    logic              active_reg, active_next;
    logic [7:0]        exp_reg, exp_next;
    logic [5:0]        rule_reg, rule_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]        term_reg, term_next;
    logic [2:0]        status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr, tab_raddr;
    logic [6:0]        tab_wdata, tab_rdata;
    logic              sym_we;
    logic [SYM_AW-1:0] sym_waddr, sym_raddr;
    logic [4:0]        sym_wdata, sym_rdata;
    logic              len_we;
    logic [LEN_AW-1:0] len_waddr, len_raddr;
    logic [LEN_W-1:0]  len_wdata, len_rdata;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [4:0]        stk_wdata, stk_rdata;

    logic accept;
    logic out_free;
    logic chk_bad;
    logic ent_bad;
    logic ent_limit;
    logic len_ovf;

    ll1p_ram #(.WIDTH(7), .DEPTH(TAB_DEPTH)) u_table (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata)
    );

    ll1p_ram #(.WIDTH(5), .DEPTH(SYM_DEPTH)) u_symbols (
        .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
        .raddr(sym_raddr), .rdata(sym_rdata)
    );

    ll1p_ram #(.WIDTH(LEN_W), .DEPTH(NUM_RULES)) u_lengths (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    ll1p_ram #(.WIDTH(5), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Decisions shared by the next-state and datapath logic.
    always_comb
    begin
        chk_bad   = (32'(stk_rdata[3:0]) >= NUM_NONTERMINALS)
                    || (32'(term_reg) >= NUM_TERMINALS);
        ent_bad   = !tab_rdata[6] || (32'(tab_rdata[5:0]) >= NUM_RULES);
        ent_limit = (exp_reg >= cfg.expansion_limit);
        len_ovf   = (32'(sp_reg) - 32'd1 + 32'(len_rdata)) > STACK_DEPTH;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == TAB_AW'(TAB_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_START)
                    begin
                        state_next = S_START1;
                    end
                    else if (req.opcode == OP_TOKEN && active_reg)
                    begin
                        state_next = S_TOP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_START1: state_next = S_DONE;
            S_TOP:    state_next = (sp_reg == '0) ? S_DONE : S_CHK;
            S_CHK:    state_next = (!stk_rdata[4] || chk_bad) ? S_DONE : S_ENT;
            S_ENT:    state_next = (ent_bad || ent_limit) ? S_DONE : S_LEN;
            S_LEN:
            begin
                if (len_ovf)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = (len_rdata == '0) ? S_TOP : S_PRD;
                end
            end
            S_PRD:    state_next = S_PWR;
            S_PWR:    state_next = (cnt_reg == LEN_W'(1)) ? S_TOP : S_PRD;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next       = clr_reg;
        sp_next        = sp_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        exp_next       = exp_reg;
        rule_next      = rule_reg;
        cnt_next       = cnt_reg;
        term_next      = term_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        tab_we         = 1'b0;
        tab_waddr      = TAB_AW'(32'(req.nonterminal) * NUM_TERMINALS + 32'(req.terminal));
        tab_wdata      = {req.entry_valid, req.rule_number};
        tab_raddr      = TAB_AW'(32'(stk_rdata[3:0]) * NUM_TERMINALS + 32'(term_reg));
        sym_we         = 1'b0;
        sym_waddr      = SYM_AW'(32'(req.rule_number) * MAX_RULE_LENGTH
                                 + 32'(req.position_in_rule));
        sym_wdata      = req.symbol_code;
        sym_raddr      = SYM_AW'(32'(rule_reg) * MAX_RULE_LENGTH + 32'(cnt_reg) - 32'd1);
        len_we         = 1'b0;
        len_waddr      = LEN_AW'(req.rule_number);
        len_wdata      = (32'(req.rule_length) > MAX_RULE_LENGTH)
                         ? LEN_W'(MAX_RULE_LENGTH) : LEN_W'(req.rule_length);
        len_raddr      = LEN_AW'(tab_rdata[5:0]);
        stk_we         = 1'b0;
        stk_waddr      = STK_AW'(sp_reg);
        stk_wdata      = sym_rdata;
        stk_raddr      = STK_AW'(sp_reg - SP_W'(1));

        case (state_reg)
            S_CLEAR:
            begin
                tab_we    = 1'b1;
                tab_waddr = clr_reg;
                tab_wdata = '0;
                clr_next  = clr_reg + TAB_AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    exp_next    = '0;
                    term_next   = req.terminal;
                    status_next = ST_WRITTEN;
                    case (req.opcode)
                        OP_START:
                        begin
                            stk_we      = 1'b1;
                            stk_waddr   = '0;
                            stk_wdata   = {1'b0, cfg.end_marker_terminal};
                            status_next = ST_STARTED;
                        end
                        OP_TOKEN:
                        begin
                            if (!active_reg)
                            begin
                                status_next = ST_IDLE;
                            end
                        end
                        OP_TABLE:
                        begin
                            tab_we = (32'(req.nonterminal) < NUM_NONTERMINALS)
                                     && (32'(req.terminal) < NUM_TERMINALS);
                        end
                        OP_SYMBOL:
                        begin
                            sym_we = (32'(req.rule_number) < NUM_RULES)
                                     && (32'(req.position_in_rule) < MAX_RULE_LENGTH);
                        end
                        OP_LENGTH:
                        begin
                            len_we = (32'(req.rule_number) < NUM_RULES);
                        end
                        default:
                        begin
                            status_next = ST_WRITTEN;
                        end
                    endcase
                end
            end
            S_START1:
            begin
                stk_we      = 1'b1;
                stk_waddr   = STK_AW'(1);
                stk_wdata   = {1'b1, cfg.start_variable};
                sp_next     = SP_W'(2);
                count_next  = '0;
                active_next = 1'b1;
            end
            S_TOP:
            begin
                if (sp_reg == '0)
                begin
                    status_next = ST_REJECTED;
                    active_next = 1'b0;
                end
            end
            S_CHK:
            begin
                if (!stk_rdata[4])
                begin
                    if (stk_rdata[3:0] != term_reg)
                    begin
                        status_next = ST_REJECTED;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        sp_next = sp_reg - SP_W'(1);
                        if (count_reg != 16'hFFFF)
                        begin
                            count_next = count_reg + 16'd1;
                        end
                        // Matching the last symbol on the stack ends the parse.
                        if (sp_reg == SP_W'(1))
                        begin
                            status_next = ST_ACCEPTED;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            status_next = ST_MATCHED;
                        end
                    end
                end
                else if (chk_bad)
                begin
                    status_next = ST_REJECTED;
                    active_next = 1'b0;
                end
            end
            S_ENT:
            begin
                if (ent_bad)
                begin
                    status_next = ST_REJECTED;
                    active_next = 1'b0;
                end
                else if (ent_limit)
                begin
                    status_next = ST_FAULT;
                    active_next = 1'b0;
                end
                else
                begin
                    rule_next = tab_rdata[5:0];
                end
            end
            S_LEN:
            begin
                if (len_ovf)
                begin
                    status_next = ST_FAULT;
                    active_next = 1'b0;
                end
                else
                begin
                    sp_next  = sp_reg - SP_W'(1);
                    cnt_next = len_rdata;
                    if (len_rdata == '0)
                    begin
                        exp_next = exp_reg + 8'd1;
                    end
                end
            end
            S_PWR:
            begin
                // The right-hand side goes on from its last symbol to its first.
                stk_we   = 1'b1;
                sp_next  = sp_reg + SP_W'(1);
                cnt_next = cnt_reg - LEN_W'(1);
                if (cnt_reg == LEN_W'(1))
                begin
                    exp_next = exp_reg + 8'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.status          = status_reg;
                    rsp_next.token_position  = count_reg;
                    rsp_next.expansions_done = exp_reg;
                    rsp_next.stack_level     = 7'(sp_reg);
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            exp_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            exp_reg       <= exp_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rule_reg   <= rule_next;
        term_reg   <= term_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= STACK_DEPTH)
        else $error("stack pointer beyond stack depth");

    a_exp_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_CLEAR) |-> exp_reg <= cfg.expansion_limit)
        else $error("expansion count passed the limit");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_RULE_LENGTH)
        else $error("push count longer than a rule");

    a_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(state_reg) == S_START1)
        else $error("parse became active without a start request");

endmodule

`default_nettype wire

// ===== rtl/ll1_table_driven_parser_unit.sv =====
// Top level of the LL(1) predictive parser: configuration registers behind
// the APB-style port, and the parser core. Depends on ll1p_pkg and ll1p_core.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  ll1p_pkg::req_t
//   rsp       out        rsp_valid/rsp_stall  ll1p_pkg::rsp_t
//   config    in         psel/penable/pwrite  paddr, pwdata, prdata
//
// Table, symbol and length writes go from S_IDLE to S_DONE, start requests by
// way of S_START1. A token passes S_TOP, S_CHK, S_ENT and S_LEN per expansion,
// S_PRD and S_PWR per symbol pushed, S_TOP and S_CHK for the final terminal
// check, then S_DONE, as set by the single read port of the stack and rule memories.
// After reset a clearing pass over all NUM_NONTERMINALS*NUM_TERMINALS entries
// empties the prediction table while req_stall is high.
// One request is in work at a time; a result waits for a free output register,
// is held there while rsp_stall is high, and frees the core once it is loaded.
`default_nettype none

module ll1_table_driven_parser_unit #(
    parameter int NUM_NONTERMINALS = ll1p_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_TERMINALS    = ll1p_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_RULES        = ll1p_pkg::NUM_RULES_DEF,
    parameter int MAX_RULE_LENGTH  = ll1p_pkg::MAX_RULE_LENGTH_DEF,
    parameter int STACK_DEPTH      = ll1p_pkg::STACK_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ll1p_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ll1p_pkg::rsp_t      rsp,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);

    import ll1p_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_START_VARIABLE: cfg_next.start_variable      = pwdata[3:0];
                REG_END_MARKER:     cfg_next.end_marker_terminal = pwdata[3:0];
                REG_EXP_LIMIT:      cfg_next.expansion_limit     = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_START_VARIABLE: prdata = {28'd0, cfg_reg.start_variable};
            REG_END_MARKER:     prdata = {28'd0, cfg_reg.end_marker_terminal};
            REG_EXP_LIMIT:      prdata = {24'd0, cfg_reg.expansion_limit};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_variable      <= START_VARIABLE_RST;
            cfg_reg.end_marker_terminal <= END_MARKER_RST;
            cfg_reg.expansion_limit     <= EXP_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ll1p_core #(
        .NUM_NONTERMINALS(NUM_NONTERMINALS),
        .NUM_TERMINALS(NUM_TERMINALS),
        .NUM_RULES(NUM_RULES),
        .MAX_RULE_LENGTH(MAX_RULE_LENGTH),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg(cfg_reg)
    );

endmodule

`default_nettype wire
